// ===== rtl/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, constants and helpers for the LC-3 instruction executor.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int unsigned MemWords = 65536;
  localparam int unsigned MemAddrW = $clog2(MemWords);
  localparam int unsigned WordW    = 16;
  localparam int unsigned RegCount = 8;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned FlagW    = 3;

  localparam logic [WordW-1:0]   PcReset = 16'h3000;
  localparam logic [RegIdxW-1:0] LinkReg = 3'd7;

  localparam logic [FlagW-1:0] FlagN = 3'b100;
  localparam logic [FlagW-1:0] FlagZ = 3'b010;
  localparam logic [FlagW-1:0] FlagP = 3'b001;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_SETPC = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_BR  = 4'd0,
    OP_ADD = 4'd1,
    OP_LD  = 4'd2,
    OP_JSR = 4'd4,
    OP_AND = 4'd5,
    OP_RTI = 4'd8,
    OP_NOT = 4'd9,
    OP_JMP = 4'd12,
    OP_RES = 4'd13
  } op_e;

  function automatic word_t sext5(input logic [4:0] v);
    return {{(WordW-5){v[4]}}, v};
  endfunction

  function automatic word_t sext9(input logic [8:0] v);
    return {{(WordW-9){v[8]}}, v};
  endfunction

  function automatic word_t sext11(input logic [10:0] v);
    return {{(WordW-11){v[10]}}, v};
  endfunction

  function automatic logic [FlagW-1:0] flags_of(input word_t v);
    logic [FlagW-1:0] f;
    if (v == '0) begin
      f = FlagZ;
    end else if (v[WordW-1]) begin
      f = FlagN;
    end else begin
      f = FlagP;
    end
    return f;
  endfunction

endpackage

// ===== rtl/lc3_ram.sv =====
// ----------------------------------------------------------------------------
// lc3_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module lc3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lc3_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 core subset: memory writes, PC loads and single-instruction execution.
// Input words: a new word is not taken while the previous one is in stage 1;
// the main memory read port serves the fetch in the accept cycle and the LD
// operand in the next one.
// Reset: R0-R7 read zero (per-register valid bits), PC = 0x3000, flags = Z,
// not halted; main memory contents are unknown until written.
// ----------------------------------------------------------------------------
module lc3_instruction_executor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [lc3_pkg::WordW-1:0]  address_i,
  input  logic [lc3_pkg::WordW-1:0]  data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lc3_pkg::WordW-1:0]  next_pc_o,
  output logic [lc3_pkg::WordW-1:0]  instruction_o,
  output logic                       reg_written_o,
  output logic [lc3_pkg::RegIdxW-1:0] dest_index_o,
  output logic [lc3_pkg::WordW-1:0]  dest_value_o,
  output logic [lc3_pkg::FlagW-1:0]  flags_o,
  output logic                       fault_o
);
  import lc3_pkg::*;

  // architectural state
  word_t              pc_q, pc_d;
  logic [FlagW-1:0]   flags_q, flags_d;
  logic               halted_q, halted_d;
  logic [RegCount-1:0] reg_vld_q;

  // pipeline control
  logic s1_v_q, s2_v_q, out_v_q;
  logic accept, out_free, s2_done;

  // stage payload
  mode_e mode_s1_q, mode_s2_q;
  word_t addr_s2_q, instr_s2_q;
  logic  a_vld_q, b_vld_q;

  // memory ports
  logic                mem_re;
  logic [MemAddrW-1:0] mem_raddr;
  word_t               mem_rdata;
  logic                rf_re;
  logic [RegIdxW-1:0]  rf_a_addr, rf_b_addr;
  word_t               rf_a_rdata, rf_b_rdata;
  logic                rf_we;

  // decode in stage 1 (instruction word on the memory read data)
  op_e   op_s1;
  word_t ld_addr;

  // execute
  word_t            reg_a, reg_b, operand_b, pc_inc;
  op_e              op_s2;
  logic             exec;
  word_t            instr_res, value_res;
  logic             wrote_res;
  logic [RegIdxW-1:0] dest_res;

  // output register
  word_t              next_pc_q, instr_q, value_q;
  logic               wrote_q, fault_q;
  logic [RegIdxW-1:0] dest_q;
  logic [FlagW-1:0]   flags_out_q;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s2_done    = s2_v_q && out_free;
  // stage 1 never overlaps stage 2, so register reads never race a write-back
  assign in_stall_o = s1_v_q || (s2_v_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- memories
  assign op_s1   = op_e'(mem_rdata[15:12]);
  // LD offset is relative to the incremented PC
  assign ld_addr = pc_inc + sext9(mem_rdata[8:0]);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pc_d;
    if (s1_v_q) begin
      mem_raddr = ld_addr;
      mem_re    = (mode_s1_q == MODE_EXEC) && (op_s1 == OP_LD);
    end else if (accept) begin
      mem_re = (mode_e'(mode_i) == MODE_EXEC);
    end
  end

  lc3_ram #(
    .Width (WordW),
    .Depth (MemWords)
  ) u_main_mem (
    .clk_i   (clk_i),
    .we_i    (accept && (mode_e'(mode_i) == MODE_WRITE)),
    .waddr_i (address_i),
    .wdata_i (data_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rf_re     = s1_v_q;
  assign rf_a_addr = mem_rdata[8:6];
  assign rf_b_addr = mem_rdata[2:0];
  assign rf_we     = s2_done && wrote_res;

  // two copies of the register file give two read ports
  lc3_ram #(
    .Width (WordW),
    .Depth (RegCount)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (dest_res),
    .wdata_i (value_res),
    .re_i    (rf_re),
    .raddr_i (rf_a_addr),
    .rdata_o (rf_a_rdata)
  );

  lc3_ram #(
    .Width (WordW),
    .Depth (RegCount)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (dest_res),
    .wdata_i (value_res),
    .re_i    (rf_re),
    .raddr_i (rf_b_addr),
    .rdata_o (rf_b_rdata)
  );

  // ----------------------------------------------------------------- execute
  assign reg_a     = a_vld_q ? rf_a_rdata : '0;
  assign reg_b     = b_vld_q ? rf_b_rdata : '0;
  assign op_s2     = op_e'(instr_s2_q[15:12]);
  assign pc_inc    = pc_q + 16'd1;
  assign exec      = (mode_s2_q == MODE_EXEC) && !halted_q;
  assign operand_b = instr_s2_q[5] ? sext5(instr_s2_q[4:0]) : reg_b;

  always_comb begin
    pc_d      = pc_q;
    flags_d   = flags_q;
    halted_d  = halted_q;
    instr_res = '0;
    wrote_res = 1'b0;
    dest_res  = '0;
    value_res = '0;
    if (s2_v_q) begin
      if (mode_s2_q == MODE_SETPC) begin
        pc_d     = addr_s2_q;
        halted_d = 1'b0;
      end else if (exec) begin
        instr_res = instr_s2_q;
        pc_d      = pc_inc;
        case (op_s2)
          OP_ADD: begin
            wrote_res = 1'b1;
            dest_res  = instr_s2_q[11:9];
            value_res = reg_a + operand_b;
          end
          OP_AND: begin
            wrote_res = 1'b1;
            dest_res  = instr_s2_q[11:9];
            value_res = reg_a & operand_b;
          end
          OP_NOT: begin
            wrote_res = 1'b1;
            dest_res  = instr_s2_q[11:9];
            value_res = ~reg_a;
          end
          OP_BR: begin
            if ((instr_s2_q[11:9] & flags_q) != '0) begin
              pc_d = pc_inc + sext9(instr_s2_q[8:0]);
            end
          end
          OP_JMP: begin
            pc_d = reg_a;
          end
          OP_JSR: begin
            // link is R7; flags untouched, target uses the old base register
            wrote_res = 1'b1;
            dest_res  = LinkReg;
            value_res = pc_inc;
            pc_d      = instr_s2_q[11] ? pc_inc + sext11(instr_s2_q[10:0]) : reg_a;
          end
          OP_LD: begin
            wrote_res = 1'b1;
            dest_res  = instr_s2_q[11:9];
            value_res = mem_rdata;
          end
          OP_RES, OP_RTI: begin
            halted_d = 1'b1;
          end
          default: begin
          end
        endcase
        if (wrote_res && (op_s2 != OP_JSR)) begin
          flags_d = flags_of(value_res);
        end
      end
    end
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      pc_q      <= PcReset;
      flags_q   <= FlagZ;
      halted_q  <= 1'b0;
      reg_vld_q <= '0;
    end else begin
      s1_v_q <= accept;
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_done) begin
        s2_v_q <= 1'b0;
      end
      if (s2_done) begin
        out_v_q  <= 1'b1;
        pc_q     <= pc_d;
        flags_q  <= flags_d;
        halted_q <= halted_d;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (rf_we) begin
        reg_vld_q[dest_res] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_s1_q <= mode_e'(mode_i);
    end
    if (s1_v_q) begin
      mode_s2_q  <= mode_s1_q;
      instr_s2_q <= mem_rdata;
      a_vld_q    <= reg_vld_q[rf_a_addr];
      b_vld_q    <= reg_vld_q[rf_b_addr];
    end
    if (accept) begin
      addr_s2_q <= address_i;
    end
    if (s2_done) begin
      next_pc_q   <= pc_d;
      instr_q     <= instr_res;
      wrote_q     <= wrote_res;
      dest_q      <= dest_res;
      value_q     <= value_res;
      flags_out_q <= flags_d;
      fault_q     <= halted_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign next_pc_o     = next_pc_q;
  assign instruction_o = instr_q;
  assign reg_written_o = wrote_q;
  assign dest_index_o  = dest_q;
  assign dest_value_o  = value_q;
  assign flags_o       = flags_out_q;
  assign fault_o       = fault_q;

  // -------------------------------------------------------------- assertions
  a_stage_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_v_q && s2_v_q))
    else $error("decode and execute stages both occupied");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q && !s2_v_q)
    else $error("accepted word did not enter stage 1 alone");

  a_s2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && out_v_q && out_stall_i |=> s2_v_q && $stable(pc_q))
    else $error("execute stage lost a word or PC moved under a stall");

endmodule

// ===== tb/lc3_instruction_executor_test.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor_test
// Drives memory writes, PC loads and instruction steps into the LC-3 executor
// and checks every result word against a shadow copy of the core state. A
// directed program comes first, then constrained-by-state random programs.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lc3_pkg::*;

  localparam int unsigned TotalWords = 1550;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainWait  = 8;

  typedef struct packed {
    word_t              next_pc;
    word_t              instruction;
    logic               reg_written;
    logic [RegIdxW-1:0] dest_index;
    word_t              dest_value;
    logic [FlagW-1:0]   flags;
    logic               fault;
  } result_t;

  // Shadow of the architectural state; predicts one result per input word.
  class lc3_shadow_core;
    word_t            regs [RegCount];
    word_t            pc;
    logic [FlagW-1:0] flags;
    bit               halted;
    word_t            mem [MemWords];
    bit               mem_set [MemWords];
    result_t          pending_results [$];
    int unsigned      errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc     = PcReset;
      flags  = FlagZ;
      halted = 1'b0;
      errors = 0;
    endfunction

    function void take_word(mode_e m, word_t a, word_t d);
      result_t r;
      word_t   ir;
      word_t   operand;
      word_t   link;
      r  = '0;
      ir = '0;
      case (m)
        MODE_WRITE: begin
          mem[a]     = d;
          mem_set[a] = 1'b1;
        end
        MODE_SETPC: begin
          pc     = a;
          halted = 1'b0;
        end
        MODE_EXEC: begin
          if (!halted) begin
            ir = mem[pc];
            pc = pc + 16'd1;
            r.instruction = ir;
            case (ir[15:12])
              OP_ADD, OP_AND: begin
                operand = ir[5] ? {{11{ir[4]}}, ir[4:0]} : regs[ir[2:0]];
                r.dest_value  = (ir[15:12] == OP_ADD) ? regs[ir[8:6]] + operand
                                                      : regs[ir[8:6]] & operand;
                r.reg_written = 1'b1;
                r.dest_index  = ir[11:9];
              end
              OP_NOT: begin
                r.dest_value  = ~regs[ir[8:6]];
                r.reg_written = 1'b1;
                r.dest_index  = ir[11:9];
              end
              OP_BR: begin
                if ((ir[11:9] & flags) != '0) pc = pc + {{7{ir[8]}}, ir[8:0]};
              end
              OP_JMP: pc = regs[ir[8:6]];
              OP_JSR: begin
                // target is taken before the link lands in R7
                link = pc;
                pc   = ir[11] ? pc + {{5{ir[10]}}, ir[10:0]} : regs[ir[8:6]];
                r.dest_value  = link;
                r.reg_written = 1'b1;
                r.dest_index  = LinkReg;
              end
              OP_LD: begin
                r.dest_value  = mem[pc + {{7{ir[8]}}, ir[8:0]}];
                r.reg_written = 1'b1;
                r.dest_index  = ir[11:9];
              end
              OP_RES, OP_RTI: halted = 1'b1;
              default: ;
            endcase
            if (r.reg_written) begin
              regs[r.dest_index] = r.dest_value;
              if (ir[15:12] != OP_JSR) begin
                flags = (r.dest_value == '0) ? FlagZ :
                        r.dest_value[WordW-1] ? FlagN : FlagP;
              end
            end
          end
        end
        default: ;
      endcase
      r.next_pc = pc;
      r.flags   = flags;
      r.fault   = halted;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no expected word pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("instruction", want.instruction, got.instruction);
      compare_field("reg_written", want.reg_written, got.reg_written);
      compare_field("dest_index", want.dest_index, got.dest_index);
      compare_field("dest_value", want.dest_value, got.dest_value);
      compare_field("flags", want.flags, got.flags);
      compare_field("fault", want.fault, got.fault);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  mode_e              mode_i = MODE_NOP;
  word_t              address_i = '0;
  word_t              data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  word_t              next_pc_o;
  word_t              instruction_o;
  logic               reg_written_o;
  logic [RegIdxW-1:0] dest_index_o;
  word_t              dest_value_o;
  logic [FlagW-1:0]   flags_o;
  logic               fault_o;

  lc3_shadow_core shadow;
  int unsigned    accepted = 0;
  int unsigned    send_idle = 12;
  int unsigned    recv_stall = 62;
  int unsigned    quiet_cycles = 0;

  lc3_instruction_executor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .next_pc_o     (next_pc_o),
    .instruction_o (instruction_o),
    .reg_written_o (reg_written_o),
    .dest_index_o  (dest_index_o),
    .dest_value_o  (dest_value_o),
    .flags_o       (flags_o),
    .fault_o       (fault_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      shadow.check_result(result_t'({next_pc_o, instruction_o, reg_written_o,
                                     dest_index_o, dest_value_o, flags_o, fault_o}));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("[lc3_instruction_executor] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input mode_e m, input word_t a, input word_t d);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    address_i  <= a;
    data_i     <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accepted++;
    shadow.take_word(m, a, d);
  endtask

  // Mostly steps through code; unwritten code or LD operands get written first
  // so that no fetch or load by a running core touches an unwritten memory word.
  task automatic pick_word(output mode_e m, output word_t a, output word_t d);
    int unsigned roll;
    word_t       ir;
    word_t       target;
    logic [3:0]  opc;
    roll = $urandom_range(0, 99);
    a    = word_t'($urandom);
    d    = word_t'($urandom);
    if (roll < 4) begin
      m = MODE_WRITE;
    end else if (roll < 6) begin
      m = MODE_NOP;
    end else if (roll < 9 || (shadow.halted && roll < 75)) begin
      m = MODE_SETPC;
      if ($urandom_range(0, 1) == 0) a = PcReset;
    end else begin
      m = MODE_EXEC;
      if (!shadow.halted) begin
        ir     = shadow.mem[shadow.pc];
        target = shadow.pc + 16'd1 + {{7{ir[8]}}, ir[8:0]};
        if (!shadow.mem_set[shadow.pc]) begin
          opc = 4'($urandom_range(0, 15));
          // keep halts from cutting programs too short
          if ((opc == OP_RES || opc == OP_RTI) && $urandom_range(0, 3) != 0) opc = OP_ADD;
          m = MODE_WRITE;
          a = shadow.pc;
          d = {opc, d[11:0]};
        end else if (ir[15:12] == OP_LD && !shadow.mem_set[target]) begin
          m = MODE_WRITE;
          a = target;
        end
      end
    end
  endtask

  initial begin
    mode_e m;
    word_t a;
    word_t d;
    shadow = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed program: imm5 minimum, reg AND, NOT, BR with no condition,
    // LD, JSR back 1024 words, JSRR through R7, taken BR, RET, halts
    send_word(MODE_NOP, 16'hFFFF, 16'hFFFF);
    send_word(MODE_WRITE, 16'h3000, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});
    send_word(MODE_WRITE, 16'h3001, {OP_AND, 3'd3, 3'd1, 1'b0, 2'b00, 3'd1});
    send_word(MODE_WRITE, 16'h3002, {OP_NOT, 3'd4, 3'd1, 6'h3F});
    send_word(MODE_WRITE, 16'h3003, {OP_BR, 3'b000, 9'h1FF});
    send_word(MODE_WRITE, 16'h3004, {OP_LD, 3'd6, 9'h0FF});
    send_word(MODE_WRITE, 16'h3104, 16'h8000);
    send_word(MODE_WRITE, 16'h3005, {OP_JSR, 1'b1, 11'h400});
    send_word(MODE_WRITE, 16'h2C06, {OP_JSR, 1'b0, 2'b00, LinkReg, 6'h00});
    send_word(MODE_WRITE, 16'h3006, {OP_BR, 3'b100, 9'h001});
    send_word(MODE_WRITE, 16'h3008, {OP_JMP, 3'b000, LinkReg, 6'h00});
    send_word(MODE_WRITE, 16'h2C07, {OP_RES, 12'h000});
    repeat (10) send_word(MODE_EXEC, word_t'($urandom), word_t'($urandom));
    send_word(MODE_EXEC, 16'h0000, 16'h0000);
    send_word(MODE_WRITE, 16'h0000, {OP_RTI, 12'hFFF});
    send_word(MODE_SETPC, 16'h0000, 16'h0000);
    send_word(MODE_EXEC, 16'hFFFF, 16'h0000);

    while (accepted < TotalWords) begin
      case (accepted * 3 / TotalWords)
        0: begin
          send_idle  = 12;
          recv_stall = 62;
        end
        1: begin
          send_idle  = 62;
          recv_stall = 12;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
        end
      endcase
      pick_word(m, a, d);
      send_word(m, a, d);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("[lc3_instruction_executor] OK");
    end else begin
      $display("[lc3_instruction_executor] ERROR");
    end
    $finish;
  end

endmodule
